// File: rtl/tsh_pkg.sv
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types, constants and hash step functions for the triple string hash.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned HashW    = 32;
  localparam int unsigned ElfOutW  = 31;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [HashW-1:0] FnvPrime = 32'd16777619;
  localparam logic [HashW-1:0] PolyMult = 32'd31;

  // One queued operation: a string byte or the string terminator.
  typedef struct packed {
    logic             term;
    logic [ByteW-1:0] data;
  } op_t;

  // ELF/PJW step. The running value never has its top nibble set, so the
  // left shift only drops zeros. Folding the new top nibble into bits 7:4
  // and clearing it is harmless when that nibble is zero.
  function automatic logic [HashW-1:0] elf_step(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] sum;
    sum = {h[HashW-5:0], 4'h0} + {{(HashW-ByteW){1'b0}}, b};
    return {4'h0, sum[27:8], sum[7:4] ^ sum[31:28], sum[3:0]};
  endfunction

  function automatic logic [HashW-1:0] fnv_step(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] prod;
    prod = h * FnvPrime;
    return prod ^ {{(HashW-ByteW){1'b0}}, b};
  endfunction

  function automatic logic [HashW-1:0] poly_step(input logic [HashW-1:0] h,
                                                 input logic [ByteW-1:0] b);
    logic [HashW-1:0] prod;
    prod = h * PolyMult;
    return prod + {{(HashW-ByteW){1'b0}}, b};
  endfunction

endpackage

// File: rtl/tsh_front.sv
// ----------------------------------------------------------------------------
// tsh_front
// Accepts string bytes, marks terminators and holds them in a short queue.
// ----------------------------------------------------------------------------
module tsh_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [tsh_pkg::ByteW-1:0] in_data_byte,
  output logic                     q_valid,
  output tsh_pkg::op_t             q_op,
  input  logic                     q_pop
);

  tsh_pkg::op_t                  mem_r [tsh_pkg::QDepth];
  logic [tsh_pkg::QPtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tsh_pkg::QPtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tsh_pkg::QCntW-1:0]     count_r, count_nxt;
  logic                          push;
  logic                          pop;
  tsh_pkg::op_t                  new_op;

  assign in_stall = (count_r == tsh_pkg::QCntW'(tsh_pkg::QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_op     = mem_r[rd_ptr_r];

  always_comb begin
    new_op.term = (in_data_byte == '0);
    new_op.data = in_data_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_op;
    end
  end

endmodule

// File: rtl/tsh_back.sv
// ----------------------------------------------------------------------------
// tsh_back
// Runs the three hash updates and holds the finished result for transfer.
// ----------------------------------------------------------------------------
module tsh_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  tsh_pkg::op_t                q_op,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tsh_pkg::ElfOutW-1:0] out_elf_result,
  output logic [tsh_pkg::HashW-1:0]   out_fnv_result,
  output logic [tsh_pkg::HashW-1:0]   out_poly_result
);

  logic [tsh_pkg::HashW-1:0]   elf_r, elf_nxt;
  logic [tsh_pkg::HashW-1:0]   fnv_r, fnv_nxt;
  logic [tsh_pkg::HashW-1:0]   poly_r, poly_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [tsh_pkg::ElfOutW-1:0] elf_out_r;
  logic [tsh_pkg::HashW-1:0]   fnv_out_r;
  logic [tsh_pkg::HashW-1:0]   poly_out_r;
  logic                        out_free;
  logic                        emit;

  // Bytes never wait; a terminator waits only for the output register.
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && (!q_op.term || out_free);
  assign emit     = q_pop && q_op.term;

  always_comb begin
    elf_nxt  = elf_r;
    fnv_nxt  = fnv_r;
    poly_nxt = poly_r;
    if (q_pop) begin
      if (q_op.term) begin
        elf_nxt  = '0;
        fnv_nxt  = '0;
        poly_nxt = '0;
      end else begin
        elf_nxt  = tsh_pkg::elf_step(elf_r, q_op.data);
        fnv_nxt  = tsh_pkg::fnv_step(fnv_r, q_op.data);
        poly_nxt = tsh_pkg::poly_step(poly_r, q_op.data);
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elf_r       <= '0;
      fnv_r       <= '0;
      poly_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      elf_r       <= elf_nxt;
      fnv_r       <= fnv_nxt;
      poly_r      <= poly_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      elf_out_r  <= elf_r[tsh_pkg::ElfOutW-1:0];
      fnv_out_r  <= fnv_r;
      poly_out_r <= poly_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_elf_result  = elf_out_r;
  assign out_fnv_result  = fnv_out_r;
  assign out_poly_result = poly_out_r;

endmodule

// File: rtl/triple_string_hash.sv
// ----------------------------------------------------------------------------
// triple_string_hash
// ELF/PJW, FNV-1 (zero basis) and multiply-by-31 hashes of a byte string.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  --------------------------------
//   in_       input      in_valid / in_stall  in_data_byte (8b, 0 = end)
//   out_      output     out_valid/out_stall  out_elf_result (31b),
//                                             out_fnv_result, out_poly_result
//
// One byte is taken per cycle while in_stall is low. A byte is written into
// the queue when it is transferred and reaches the hash registers when it
// leaves the queue. A terminator's result is loaded into the output register
// at the same edge at which the terminator leaves the queue, and is offered
// from there. The timing limit is the FNV multiply by a constant feeding the
// running hash register.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and clears all three running hashes. An output stall holds back a terminator
// at the queue head and all entries behind it; string bytes at the head keep
// draining into the hashes; the four-entry queue raises in_stall only when full.
//
// The front part classifies each incoming byte as data or terminator and
// queues it. The back part pops one entry per cycle unless a terminator at
// the head waits on a stalled output, updates the hashes for data bytes, and
// for a terminator loads the output register and restarts the hashes from zero.
// ----------------------------------------------------------------------------
module triple_string_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsh_pkg::ByteW-1:0]   in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tsh_pkg::ElfOutW-1:0] out_elf_result,
  output logic [tsh_pkg::HashW-1:0]   out_fnv_result,
  output logic [tsh_pkg::HashW-1:0]   out_poly_result
);

  // Queue head as seen by the back part.
  logic         q_valid;
  tsh_pkg::op_t q_op;
  logic         q_pop;

  tsh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop)
  );

  tsh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_elf_result  (out_elf_result),
    .out_fnv_result  (out_fnv_result),
    .out_poly_result (out_poly_result)
  );

endmodule

// File: tb/triple_string_hash_tb.sv
// ----------------------------------------------------------------------------
// triple_string_hash_tb
// Self-checking bench for the ELF/PJW, FNV-1 and multiply-by-31 string hasher.
// Strings are streamed in byte by byte with random gaps and output stalls. A
// small scoreboard keeps its own running hashes and queues one digest per
// terminator, and every result transfer is compared field by field against
// the oldest queued digest.
// ----------------------------------------------------------------------------
module triple_string_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Hash constants, kept here so the predictor does not lean on the RTL.
  localparam logic [31:0] ElfTopNibble = 32'hF000_0000;
  localparam logic [31:0] FnvMult      = 32'd16777619;
  localparam logic [31:0] PolyMult     = 32'd31;
  localparam logic [7:0]  Terminator   = 8'h00;

  // Pacing of the run.
  localparam int unsigned IdlePct      = 6;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned WatchdogMax  = 3000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxReported  = 10;

  // One finished string: the three hashes as the block should present them.
  typedef struct {
    logic [tsh_pkg::ElfOutW-1:0] elf;
    logic [tsh_pkg::HashW-1:0]   fnv;
    logic [tsh_pkg::HashW-1:0]   poly;
  } digest_t;

  // The scoreboard mirrors the three running hashes. Every accepted byte is
  // folded into them; a terminator turns them into an awaited digest and
  // clears them, just as the block does.
  class digest_scoreboard;
    logic [31:0] elf_acc;
    logic [31:0] fnv_acc;
    logic [31:0] poly_acc;
    digest_t     awaited_digests[$];
    int unsigned mismatches;
    int unsigned strings_done;
    int unsigned bytes_taken;
    int unsigned cur_len;
    int unsigned longest;

    function new();
      elf_acc      = '0;
      fnv_acc      = '0;
      poly_acc     = '0;
      mismatches   = 0;
      strings_done = 0;
      bytes_taken  = 0;
      cur_len      = 0;
      longest      = 0;
    endfunction

    // Called for every input transfer.
    function void absorb_byte(logic [tsh_pkg::ByteW-1:0] b);
      logic [31:0] top;
      digest_t     d;
      bytes_taken++;
      if (b != Terminator) begin
        // ELF/PJW: shift in the byte, then fold the top nibble down and drop it.
        elf_acc = (elf_acc << 4) + {24'h0, b};
        top     = elf_acc & ElfTopNibble;
        if (top != 0) begin
          elf_acc = elf_acc ^ (top >> 24);
          elf_acc = elf_acc & ~top;
        end
        fnv_acc  = (fnv_acc * FnvMult) ^ {24'h0, b};
        poly_acc = poly_acc * PolyMult + {24'h0, b};
        cur_len++;
      end else begin
        d.elf  = elf_acc[tsh_pkg::ElfOutW-1:0];
        d.fnv  = fnv_acc;
        d.poly = poly_acc;
        awaited_digests.push_back(d);
        if (cur_len > longest) longest = cur_len;
        cur_len  = 0;
        elf_acc  = '0;
        fnv_acc  = '0;
        poly_acc = '0;
      end
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= MaxReported)
        $display("[%0t] string %0d: %s mismatch, expected 0x%08h, got 0x%08h",
                 $realtime, strings_done, what, exp_v, act_v);
    endfunction

    // Called for every result transfer.
    function void check_digest(logic [tsh_pkg::ElfOutW-1:0] elf,
                               logic [tsh_pkg::HashW-1:0] fnv,
                               logic [tsh_pkg::HashW-1:0] poly);
      digest_t d;
      if (awaited_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("[%0t] result with no string pending: elf 0x%08h fnv 0x%08h poly 0x%08h",
                   $realtime, elf, fnv, poly);
        return;
      end
      d = awaited_digests.pop_front();
      if (elf !== d.elf)   flag("elf",  {1'b0, d.elf}, {1'b0, elf});
      if (fnv !== d.fnv)   flag("fnv",  d.fnv,  fnv);
      if (poly !== d.poly) flag("poly", d.poly, poly);
      strings_done++;
    endfunction

    function int unsigned pending();
      return awaited_digests.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [tsh_pkg::ByteW-1:0]   in_data_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [tsh_pkg::ElfOutW-1:0] out_elf_result;
  logic [tsh_pkg::HashW-1:0]   out_fnv_result;
  logic [tsh_pkg::HashW-1:0]   out_poly_result;

  // Set while neither side may idle; set once to start the long output hold.
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  digest_scoreboard sb = new();
  int unsigned      items_sent = 0;

  triple_string_hash u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_elf_result  (out_elf_result),
    .out_fnv_result  (out_fnv_result),
    .out_poly_result (out_poly_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Both monitors sample at the rising edge, so they see the values that
  // were present just before it, which is exactly what the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.absorb_byte(in_data_byte);
    if (rst_n && out_valid && !out_stall)
      sb.check_digest(out_elf_result, out_fnv_result, out_poly_result);
  end

  // The watchdog ends the run once nothing has moved on either channel for
  // far longer than the long output hold plus the deepest backlog needs.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogMax) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog expired after %0d cycles without a transfer", WatchdogMax);
    $display("simulation failed");
    $finish;
  end

  // The result side. It normally stalls now and then at random; once the
  // stimulus raises hold_req it holds off for a long stretch so that results
  // back up, the queue inside the block fills and the input gets stalled.
  initial begin : result_sink
    logic hold_used;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Offers one byte and returns at the edge where it is transferred. Valid
  // is left high so back-to-back bytes need no dead cycle; any random gap
  // lowers it in a step of its own first.
  task automatic send_byte(input logic [tsh_pkg::ByteW-1:0] b);
    while (!calm && ($urandom_range(0, 99) < IdlePct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_string(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom_range(1, 255)));
    send_byte(Terminator);
  endtask

  // Mostly short strings, some medium ones, and a few long enough for all
  // three hashes to wrap many times over.
  task automatic send_random_strings(input int unsigned until_items);
    int unsigned pick;
    while (items_sent < until_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 85)      send_string($urandom_range(0, 10));
      else if (pick < 95) send_string($urandom_range(11, 30));
      else                send_string($urandom_range(40, 80));
    end
  endtask

  // Drops valid and waits until every string handed in has been answered.
  task automatic wait_all_answered();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: the empty string, single bytes at the extremes, a
    // mixed pattern, and a run of 0xFF bytes that forces the ELF hash to
    // fold its top nibble repeatedly.
    send_byte(Terminator);
    send_byte(8'hFF);
    send_byte(Terminator);
    send_byte(8'h01);
    send_byte(Terminator);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(Terminator);
    repeat (10) send_byte(8'hFF);
    send_byte(Terminator);

    // Random strings with idling on both sides.
    send_random_strings(700);

    // A stretch where neither side idles.
    calm <= 1'b1;
    send_random_strings(1000);
    calm <= 1'b0;

    // Long output hold: keep offering strings of at most two bytes, some of them
    // bare terminators, so the block runs out of room and stalls the input.
    hold_req <= 1'b1;
    repeat (16) send_string($urandom_range(0, 2));

    // The sender pauses until the backlog has fully drained.
    wait_all_answered();

    send_random_strings(1650);

    // Let everything come out, then idle for the drain period so the block can
    // show any result it should not produce.
    wait_all_answered();
    repeat (DrainCycles) @(posedge clk);

    $display("Hashed %0d strings from %0d byte transfers; longest string %0d bytes.",
             sb.strings_done, sb.bytes_taken, sb.longest);
    $display("Covered empty strings, 0x01..0xFF bytes, long wrapping strings and a %0d-cycle %s",
             HoldCycles, "output hold with a full input queue.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tsh_pkg.sv
rtl/tsh_front.sv
rtl/tsh_back.sv
rtl/triple_string_hash.sv
tb/triple_string_hash_tb.sv
